FILE: rtl/btkk_pkg.sv
// Shared types and constants for the bounded top-k nearest keeper.
// No dependencies; every other file refers to it by scoped names.
package btkk_pkg;

  localparam int KEY_W   = 32;
  localparam int COORD_W = 32;
  localparam int CAP_W   = 5;
  localparam int CNT_W   = 5;

  localparam logic [KEY_W-1:0] KEY_ALL_ONES = '1;
  localparam logic [CAP_W-1:0] CAP_RESET    = CAP_W'(16);

  // Request operation codes
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_READ = 1'b1;

  // Cell commands
  localparam logic [1:0] CMD_HOLD   = 2'd0;
  localparam logic [1:0] CMD_INSERT = 2'd1;
  localparam logic [1:0] CMD_ROTATE = 2'd2;

  typedef struct packed {
    logic [KEY_W-1:0]          key;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
  } entry_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       occupied;
    logic       is_tail;
  } cell_ctrl_t;

endpackage

FILE: rtl/btkk_ifs.sv
// Request and result channel interfaces of the top-k keeper.
// Depends on btkk_pkg for field widths.
interface btkk_req_if;
  logic                                valid;
  logic                                ready;
  logic                                operation;
  logic [btkk_pkg::KEY_W-1:0]          distance_key;
  logic signed [btkk_pkg::COORD_W-1:0] point_x;
  logic signed [btkk_pkg::COORD_W-1:0] point_y;

  modport source(output valid, operation, distance_key, point_x, point_y, input ready);
  modport sink(input valid, operation, distance_key, point_x, point_y, output ready);
endinterface

interface btkk_res_if;
  logic                                valid;
  logic                                ready;
  logic                                entry_valid;
  logic [btkk_pkg::KEY_W-1:0]          out_key;
  logic signed [btkk_pkg::COORD_W-1:0] out_x;
  logic signed [btkk_pkg::COORD_W-1:0] out_y;
  logic                                accepted;
  logic [btkk_pkg::CNT_W-1:0]          held_count;
  logic                                is_full;
  logic [btkk_pkg::KEY_W-1:0]          worst_key;
  logic                                last;

  modport source(output valid, entry_valid, out_key, out_x, out_y, accepted, held_count,
                 is_full, worst_key, last, input ready);
  modport sink(input valid, entry_valid, out_key, out_x, out_y, accepted, held_count,
               is_full, worst_key, last, output ready);
endinterface

FILE: rtl/btkk_cell.sv
// One slot of the sorted entry chain: holds an entry, shifts on insert,
// rotates toward the head on readout. Depends on btkk_pkg.
module btkk_cell (
  input  logic                 clk,
  input  btkk_pkg::cell_ctrl_t ctrl,
  input  btkk_pkg::entry_t     new_entry,
  input  btkk_pkg::entry_t     left_entry,
  input  btkk_pkg::entry_t     right_entry,
  input  btkk_pkg::entry_t     head_entry,
  input  logic                 take_left,
  output logic                 take,
  output btkk_pkg::entry_t     entry
);

  // Slot is at or past the insert point: empty, or key strictly larger
  assign take = !ctrl.occupied || (entry.key > new_entry.key);

  always_ff @(posedge clk) begin
    case (ctrl.cmd)
      btkk_pkg::CMD_INSERT: begin
        if (take) begin
          entry <= take_left ? left_entry : new_entry;
        end
      end
      btkk_pkg::CMD_ROTATE: begin
        if (ctrl.occupied) begin
          entry <= ctrl.is_tail ? head_entry : right_entry;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

FILE: rtl/bounded_top_k_nearest_keeper_core.sv
// Top-k smallest-key keeper built as a sorted chain of entry cells.
// Push: once accepted, its single result is loaded from ST_POST when the result register is free.
// Read of n held entries: n results, one per cycle while the result channel does not stall, as the head cell rotates.
// Read while empty: one result loaded in the accepting cycle.
// Reset (rst, synchronous): held count 0, capacity 16, channels idle; cell contents undefined.
module bounded_top_k_nearest_keeper_core #(
  parameter int MAX_ENTRIES = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wr_en,
  input  logic [btkk_pkg::CAP_W-1:0]      cfg_wr_data,
  btkk_req_if.sink                        req,
  btkk_res_if.source                      res
);

  localparam int CW   = $clog2(MAX_ENTRIES + 1);
  localparam int CAPW = (CW > btkk_pkg::CAP_W) ? CW : btkk_pkg::CAP_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_POST = 2'd1;
  localparam logic [1:0] ST_READ = 2'd2;

  logic [1:0]                    state;
  logic [CW-1:0]                 count;
  logic [CW-1:0]                 idx;
  logic [btkk_pkg::CAP_W-1:0]    capacity;
  logic                          push_accepted;
  logic [btkk_pkg::KEY_W-1:0]    worst_hold;

  logic [CW-1:0]                 eff_cap;
  logic [CW-1:0]                 limit;
  logic [CW-1:0]                 tail_idx;
  logic [1:0]                    cell_cmd;
  logic                          req_fire;
  logic                          out_free;
  logic                          res_load;
  logic                          push_room;
  logic                          push_repl;
  logic [btkk_pkg::KEY_W-1:0]    tail_key;
  logic [btkk_pkg::KEY_W-1:0]    worst_cur;
  btkk_pkg::entry_t              new_entry;

  btkk_pkg::entry_t              entries    [MAX_ENTRIES];
  btkk_pkg::entry_t              left_e     [MAX_ENTRIES];
  btkk_pkg::entry_t              right_e    [MAX_ENTRIES];
  logic                          takes      [MAX_ENTRIES];
  logic                          take_left  [MAX_ENTRIES];
  btkk_pkg::cell_ctrl_t          ctrl       [MAX_ENTRIES];

  // Capacity register value clamped to 1..MAX_ENTRIES
  function automatic logic [CW-1:0] eff_of(input logic [btkk_pkg::CAP_W-1:0] c);
    logic [CAPW-1:0] v;
    v = CAPW'(c);
    if (v == '0) begin
      v = CAPW'(1);
    end
    if (v > CAPW'(MAX_ENTRIES)) begin
      v = CAPW'(MAX_ENTRIES);
    end
    return CW'(v);
  endfunction

  assign eff_cap   = eff_of(capacity);
  assign tail_idx  = count - CW'(1);
  assign req_fire  = req.valid && req.ready;
  assign out_free  = !res.valid || res.ready;
  assign req.ready = (state == ST_IDLE) && out_free && !cfg_wr_en;

  // Result register takes a new value when it is free and one is due
  assign res_load = out_free && ((state == ST_POST) || (state == ST_READ) ||
                    (req_fire && req.operation == btkk_pkg::OP_READ && count == '0));

  assign new_entry.key = req.distance_key;
  assign new_entry.x   = req.point_x;
  assign new_entry.y   = req.point_y;

  // Largest held key sits in the tail cell
  always_comb begin
    tail_key = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      tail_key = tail_key | (entries[i].key & {btkk_pkg::KEY_W{CW'(i) == tail_idx}});
    end
    worst_cur = (count == '0) ? btkk_pkg::KEY_ALL_ONES : tail_key;
  end

  // Push decision and chain command
  always_comb begin
    push_room = count < eff_cap;
    push_repl = !push_room && (count != '0) && (req.distance_key < worst_cur);
    cell_cmd  = btkk_pkg::CMD_HOLD;
    limit     = count;
    if (req_fire && req.operation == btkk_pkg::OP_PUSH && (push_room || push_repl)) begin
      cell_cmd = btkk_pkg::CMD_INSERT;
      limit    = push_room ? count : tail_idx;
    end else if (state == ST_READ && out_free) begin
      cell_cmd = btkk_pkg::CMD_ROTATE;
    end
  end

  // Cell chain
  for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
    if (g == 0) begin : g_head
      assign left_e[g]    = new_entry;
      assign take_left[g] = 1'b0;
    end else begin : g_body
      assign left_e[g]    = entries[g-1];
      assign take_left[g] = takes[g-1];
    end
    if (g == MAX_ENTRIES - 1) begin : g_end
      assign right_e[g] = entries[g];
    end else begin : g_mid
      assign right_e[g] = entries[g+1];
    end

    assign ctrl[g].cmd      = cell_cmd;
    assign ctrl[g].occupied = CW'(g) < limit;
    assign ctrl[g].is_tail  = CW'(g) == tail_idx;

    btkk_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl[g]),
      .new_entry  (new_entry),
      .left_entry (left_e[g]),
      .right_entry(right_e[g]),
      .head_entry (entries[0]),
      .take_left  (take_left[g]),
      .take       (takes[g]),
      .entry      (entries[g])
    );
  end

  // Control sequencing and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      idx       <= '0;
      capacity  <= btkk_pkg::CAP_RESET;
      res.valid <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        capacity <= cfg_wr_data;
        if (count > eff_of(cfg_wr_data)) begin
          count <= eff_of(cfg_wr_data);
        end
      end
      if (res_load) begin
        res.valid <= 1'b1;
      end else if (res.ready) begin
        res.valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (req_fire) begin
            if (req.operation == btkk_pkg::OP_PUSH) begin
              push_accepted <= push_room || push_repl;
              if (push_room) begin
                count <= count + CW'(1);
              end
              state <= ST_POST;
            end else if (count == '0) begin
              res.entry_valid <= 1'b0;
              res.out_key     <= '0;
              res.out_x       <= '0;
              res.out_y       <= '0;
              res.accepted    <= 1'b0;
              res.held_count  <= '0;
              res.is_full     <= 1'b0;
              res.worst_key   <= btkk_pkg::KEY_ALL_ONES;
              res.last        <= 1'b1;
            end else begin
              worst_hold <= worst_cur;
              idx        <= '0;
              state      <= ST_READ;
            end
          end
        end
        ST_POST: begin
          if (out_free) begin
            res.entry_valid <= 1'b0;
            res.out_key     <= '0;
            res.out_x       <= '0;
            res.out_y       <= '0;
            res.accepted    <= push_accepted;
            res.held_count  <= btkk_pkg::CNT_W'(count);
            res.is_full     <= count == eff_cap;
            res.worst_key   <= worst_cur;
            res.last        <= 1'b1;
            state           <= ST_IDLE;
          end
        end
        ST_READ: begin
          if (out_free) begin
            res.entry_valid <= 1'b1;
            res.out_key     <= entries[0].key;
            res.out_x       <= entries[0].x;
            res.out_y       <= entries[0].y;
            res.accepted    <= 1'b0;
            res.held_count  <= btkk_pkg::CNT_W'(count);
            res.is_full     <= count == eff_cap;
            res.worst_key   <= worst_hold;
            res.last        <= idx == tail_idx;
            idx             <= idx + CW'(1);
            if (idx == tail_idx) begin
              state <= ST_IDLE;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
